// ===== rtl/core/imbl_pkg.sv =====
package imbl_pkg;

    localparam logic [1:0] ACT_BIND   = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    localparam int VAL_W = 64;

    // sequencer states
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SRCH   = 12'b000000000010,
        S_SRCHW  = 12'b000000000100,
        S_DISP   = 12'b000000001000,
        S_SHIFT  = 12'b000000010000,
        S_SHIFTW = 12'b000000100000,
        S_SPLIT  = 12'b000001000000,
        S_FILL   = 12'b000010000000,
        S_MRD    = 12'b000100000000,
        S_MRDW   = 12'b001000000000,
        S_MWR    = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } t_state;

    // search purposes
    typedef enum logic [2:0] {
        P_LOOK = 3'd0,
        P_CHK0 = 3'd1,
        P_CHK1 = 3'd2,
        P_SPL0 = 3'd3,
        P_SPL1 = 3'd4,
        P_FA   = 3'd5,
        P_FB   = 3'd6
    } t_purpose;

endpackage

// ===== rtl/core/imbl_ram.sv =====
module imbl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/interval_map_bind_lookup.sv =====
// channel   | direction | signals
// ----------+-----------+---------------------------------------------------------
// request   | in        | i_start, o_busy, i_action, i_bind_*, i_search_key, i_entry_index
// result    | out       | o_valid strobe, o_status, o_found_*, o_range_count
// config    | in        | i_cfg_valid, o_cfg_ready, i_cfg_data
//
// a lookup binary-searches the table and then reads the located entry; an index read
// reads its entry directly; a bind runs up to six binary searches, up to two shift
// passes that move entries up one place, a fill pass and a merge pass over the
// entries, all through one table read port
// synchronous active-low reset empties nothing: the table holds one full range
// the result strobe lasts one cycle; the receiver cannot stall
module interval_map_bind_lookup
    import imbl_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int KEY_WIDTH  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_action,
    input  logic [63:0]          i_bind_low,
    input  logic [63:0]          i_bind_high,
    input  logic [63:0]          i_bind_value,
    input  logic [63:0]          i_search_key,
    input  logic [5:0]           i_entry_index,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [63:0]          o_found_low,
    output logic [63:0]          o_found_high,
    output logic [63:0]          o_found_value,
    output logic [6:0]           o_range_count
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = AW + 1;
    localparam int TW = 2 * KEY_WIDTH + VAL_W;
    localparam logic [KEY_WIDTH-1:0] KEY_MAX = '1;
    localparam logic [CW-1:0] CAP = CW'(MAX_RANGES);

    // table entry: lower bound, upper bound, value
    typedef struct packed {
        logic [KEY_WIDTH-1:0] lo;
        logic [KEY_WIDTH-1:0] hi;
        logic [VAL_W-1:0]     val;
    } t_entry;

    t_state   r_state, n_state;
    t_purpose r_purp, n_purp;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_slo, n_slo, r_shi, n_shi;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_w, n_w;
    logic [AW-1:0] r_ia, n_ia, r_ib, n_ib;
    logic [1:0]    r_extra, n_extra;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_blo, r_bhi;
    logic [VAL_W-1:0]     r_bval, r_init;
    logic [1:0]    r_act;
    logic [5:0]    r_idx;
    t_entry        r_cur, n_cur;
    logic          r_valid, n_valid;
    logic [1:0]    r_stat, n_stat;
    t_entry        r_res, n_res;

    // ram ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata_raw, rdata;

    imbl_ram #(.WIDTH(TW), .DEPTH(MAX_RANGES)) u_tab (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    // entry 0 reads as the reset range until the ram holds it
    logic r_e0_written, n_e0_written;
    logic r_rd0;
    always_comb begin
        rdata = rdata_raw;
        if (r_rd0 && !r_e0_written) begin
            rdata.lo  = '0;
            rdata.hi  = KEY_MAX;
            rdata.val = r_init;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;

    // search step helpers
    logic [AW:0]   mid_sum;
    logic [AW-1:0] mid;
    assign mid_sum = {1'b0, r_slo} + {1'b0, r_shi};
    assign mid     = mid_sum[AW:1];

    logic [AW-1:0] last;
    assign last = AW'(r_count - 1'b1);

    logic top;
    assign top = (r_bhi == KEY_MAX);

    always_comb begin
        n_state = r_state;
        n_purp = r_purp;
        n_count = r_count;
        n_slo = r_slo;
        n_shi = r_shi;
        n_ptr = r_ptr;
        n_w = r_w;
        n_ia = r_ia;
        n_ib = r_ib;
        n_extra = r_extra;
        n_key = r_key;
        n_cur = r_cur;
        n_valid = 1'b0;
        n_stat = r_stat;
        n_res = r_res;
        n_e0_written = r_e0_written;
        we = 1'b0;
        waddr = r_ptr;
        wdata = r_cur;
        raddr = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_stat = ST_OK;
                    n_res = '0;
                    n_slo = '0;
                    n_shi = last;
                    case (i_action)
                        ACT_BIND: begin
                            if (i_bind_low[KEY_WIDTH-1:0] > i_bind_high[KEY_WIDTH-1:0]) begin
                                n_stat = ST_BAD_RANGE;
                                n_state = S_DONE;
                            end else begin
                                n_extra = '0;
                                n_key = i_bind_low[KEY_WIDTH-1:0];
                                n_purp = P_CHK0;
                                n_state = S_SRCH;
                            end
                        end
                        ACT_LOOKUP: begin
                            n_key = i_search_key[KEY_WIDTH-1:0];
                            n_purp = P_LOOK;
                            n_state = S_SRCH;
                        end
                        ACT_READ: begin
                            if (7'(i_entry_index) < 7'(r_count)
                                    && i_entry_index < 6'(MAX_RANGES > 63 ? 63 : MAX_RANGES)
                                    || (MAX_RANGES > 63 && 7'(i_entry_index) < 7'(r_count))) begin
                                n_ptr = AW'(i_entry_index);
                                n_purp = P_LOOK;
                                n_slo = AW'(i_entry_index);
                                n_shi = AW'(i_entry_index);
                                n_state = S_SRCH;
                            end else begin
                                n_stat = ST_BAD_INDEX;
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // one binary search step: read mid, or the located entry once the bounds meet
            S_SRCH: begin
                if (r_slo == r_shi) begin
                    raddr = r_slo;
                    n_ptr = r_slo;
                    n_state = S_DISP;
                end else begin
                    raddr = mid;
                    n_ptr = mid;
                    n_state = S_SRCHW;
                end
            end
            S_SRCHW: begin
                if (r_key > rdata.hi) n_slo = r_ptr + 1'b1;
                else n_shi = r_ptr;
                n_state = S_SRCH;
            end
            // located entry r_ptr is on the read data
            S_DISP: begin
                n_cur = rdata;
                n_slo = '0;
                n_shi = last;
                case (r_purp)
                    P_LOOK: begin
                        n_res = rdata;
                        n_state = S_DONE;
                    end
                    P_CHK0: begin
                        n_extra = (rdata.lo != r_key) ? 2'd1 : 2'd0;
                        if (top) begin
                            n_state = S_DISP;
                            n_purp = P_CHK1;
                            n_key = r_key;
                            if (CW'(r_count) + CW'((rdata.lo != r_key) ? 1 : 0) > CAP) begin
                                n_stat = ST_FULL;
                                n_state = S_DONE;
                            end else begin
                                n_key = r_blo;
                                n_purp = P_SPL0;
                                n_state = S_SRCH;
                            end
                        end else begin
                            n_key = r_bhi + 1'b1;
                            n_purp = P_CHK1;
                            n_state = S_SRCH;
                        end
                    end
                    P_CHK1: begin
                        if ((CW+1)'(r_count) + (CW+1)'(r_extra)
                                + (CW+1)'((rdata.lo != r_key) ? 1 : 0) > (CW+1)'(CAP)) begin
                            n_stat = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_key = r_blo;
                            n_purp = P_SPL0;
                            n_state = S_SRCH;
                        end
                    end
                    P_SPL0, P_SPL1: begin
                        if (rdata.lo == r_key) begin
                            n_purp = (r_purp == P_SPL0 && !top) ? P_SPL1 : P_FA;
                            n_key = (r_purp == P_SPL0 && !top) ? r_bhi + 1'b1 : r_blo;
                            n_state = S_SRCH;
                        end else begin
                            n_ia = r_ptr;
                            n_ptr = last;
                            n_state = S_SHIFT;
                        end
                    end
                    P_FA: begin
                        n_ia = r_ptr;
                        n_key = r_bhi;
                        n_purp = P_FB;
                        n_state = S_SRCH;
                    end
                    default: begin
                        n_ib = r_ptr;
                        n_ptr = r_ia;
                        n_state = S_FILL;
                    end
                endcase
            end
            // move entries up one place, from the top down to ia+1
            S_SHIFT: begin
                if (r_ptr == r_ia) begin
                    n_state = S_SPLIT;
                end else begin
                    raddr = r_ptr;
                    n_state = S_SHIFTW;
                end
            end
            S_SHIFTW: begin
                we = 1'b1;
                waddr = r_ptr + 1'b1;
                wdata = rdata;
                n_ptr = r_ptr - 1'b1;
                n_state = S_SHIFT;
            end
            // write the two halves of the split range
            S_SPLIT: begin
                we = 1'b1;
                if (r_ptr == r_ia) begin
                    waddr = r_ia + 1'b1;
                    wdata = r_cur;
                    wdata.lo = r_key;
                    n_ptr = r_ia + 1'b1;
                end else begin
                    waddr = r_ia;
                    wdata = r_cur;
                    wdata.hi = r_key - 1'b1;
                    if (r_ia == '0) n_e0_written = 1'b1;
                    n_count = r_count + 1'b1;
                    n_slo = '0;
                    n_shi = AW'(r_count);
                    n_purp = (r_purp == P_SPL0 && !top) ? P_SPL1 : P_FA;
                    n_key = (r_purp == P_SPL0 && !top) ? r_bhi + 1'b1 : r_blo;
                    n_state = S_SRCH;
                end
            end
            // give the bound value to entries ia..ib
            S_FILL: begin
                raddr = r_ptr;
                n_state = S_MRDW;
                n_purp = P_FA;
            end
            // merge pass: r_ptr reads, r_w writes, r_cur is the open run
            S_MRD: begin
                raddr = r_ptr;
                n_state = S_MRDW;
            end
            S_MRDW: begin
                if (r_purp == P_FA) begin
                    // fill: rewrite value
                    we = 1'b1;
                    waddr = r_ptr;
                    wdata = rdata;
                    wdata.val = r_bval;
                    if (r_ptr == '0) n_e0_written = 1'b1;
                    if (r_ptr == r_ib) begin
                        n_purp = P_FB;
                        n_ptr = '0;
                        n_w = '0;
                        n_state = S_MRD;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                        n_state = S_FILL;
                    end
                end else if (r_ptr == '0) begin
                    n_cur = rdata;
                    if (r_ptr == last) n_state = S_MWR;
                    else begin
                        n_ptr = r_ptr + 1'b1;
                        n_state = S_MRD;
                    end
                end else begin
                    if (rdata.val == r_cur.val) begin
                        n_cur.hi = rdata.hi;
                    end else begin
                        we = 1'b1;
                        waddr = r_w;
                        wdata = r_cur;
                        if (r_w == '0) n_e0_written = 1'b1;
                        n_w = r_w + 1'b1;
                        n_cur = rdata;
                    end
                    if (r_ptr == last) n_state = S_MWR;
                    else begin
                        n_ptr = r_ptr + 1'b1;
                        n_state = S_MRD;
                    end
                end
            end
            S_MWR: begin
                we = 1'b1;
                waddr = r_w;
                wdata = r_cur;
                if (r_w == '0) n_e0_written = 1'b1;
                n_count = CW'(r_w) + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_valid <= 1'b0;
            r_e0_written <= 1'b0;
            r_init <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_init <= i_cfg_data;
                r_count <= CW'(1);
                r_e0_written <= 1'b0;
            end else begin
                r_count <= n_count;
                r_e0_written <= n_e0_written;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_purp <= n_purp;
        r_slo <= n_slo;
        r_shi <= n_shi;
        r_ptr <= n_ptr;
        r_w <= n_w;
        r_ia <= n_ia;
        r_ib <= n_ib;
        r_extra <= n_extra;
        r_key <= n_key;
        r_cur <= n_cur;
        r_stat <= n_stat;
        r_res <= n_res;
        r_rd0 <= (raddr == '0);
        if (r_state == S_IDLE && i_start) begin
            r_blo <= i_bind_low[KEY_WIDTH-1:0];
            r_bhi <= i_bind_high[KEY_WIDTH-1:0];
            r_bval <= i_bind_value;
            r_act <= i_action;
            r_idx <= i_entry_index;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_stat;
    assign o_found_low   = 64'(r_res.lo);
    assign o_found_high  = 64'(r_res.hi);
    assign o_found_value = r_res.val;
    assign o_range_count = 7'(r_count);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= CAP) else $error("range count out of bounds");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("busy while result shown");
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_act == ACT_READ && o_status == ST_OK) |-> 7'(r_idx) < o_range_count)
        else $error("index read beyond count");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import imbl_pkg::*;

    localparam int          DEPTH    = 64;
    localparam logic [63:0] KEY_TOP  = 64'hffff_ffff_ffff_ffff;
    localparam int          SETTLE   = 1200;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] bind_low;
        logic [63:0] bind_high;
        logic [63:0] bind_value;
        logic [63:0] search_key;
        logic [5:0]  entry_index;
    } t_request;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] found_low;
        logic [63:0] found_high;
        logic [63:0] found_value;
        logic [6:0]  range_count;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_action = '0;
    logic [63:0] i_bind_low = '0;
    logic [63:0] i_bind_high = '0;
    logic [63:0] i_bind_value = '0;
    logic [63:0] i_search_key = '0;
    logic [5:0]  i_entry_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [63:0] o_found_low;
    logic [63:0] o_found_high;
    logic [63:0] o_found_value;
    logic [6:0]  o_range_count;

    interval_map_bind_lookup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_action(i_action), .i_bind_low(i_bind_low), .i_bind_high(i_bind_high),
        .i_bind_value(i_bind_value), .i_search_key(i_search_key),
        .i_entry_index(i_entry_index), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .o_status(o_status), .o_found_low(o_found_low),
        .o_found_high(o_found_high), .o_found_value(o_found_value),
        .o_range_count(o_range_count)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the range table
    logic [63:0] tbl_low [DEPTH];
    logic [63:0] tbl_high[DEPTH];
    logic [63:0] tbl_val [DEPTH];
    int          tbl_count;

    t_request pending_q[$];
    t_answer  answer_q[$];
    int       errors = 0;
    int       n_results = 0;
    int       n_full = 0;
    bit       quiet_sender = 1'b0;

    function automatic void table_reinit(logic [63:0] v);
        for (int k = 0; k < DEPTH; k++) begin
            tbl_low[k] = '0;
            tbl_high[k] = '0;
            tbl_val[k] = '0;
        end
        tbl_high[0] = KEY_TOP;
        tbl_val[0] = v;
        tbl_count = 1;
    endfunction

    function automatic int find_range(logic [63:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count - 1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key > tbl_high[mid]) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic void cut_at(logic [63:0] key);
        int i;
        i = find_range(key);
        if (tbl_low[i] == key || tbl_count >= DEPTH) return;
        for (int j = tbl_count; j > i + 1; j--) begin
            tbl_low[j] = tbl_low[j-1];
            tbl_high[j] = tbl_high[j-1];
            tbl_val[j] = tbl_val[j-1];
        end
        tbl_low[i+1] = key;
        tbl_high[i+1] = tbl_high[i];
        tbl_val[i+1] = tbl_val[i];
        tbl_high[i] = key - 64'd1;
        tbl_count++;
    endfunction

    function automatic void join_equal();
        int w;
        w = 0;
        for (int r = 1; r < tbl_count; r++) begin
            if (tbl_val[r] == tbl_val[w]) begin
                tbl_high[w] = tbl_high[r];
            end else begin
                w++;
                tbl_low[w] = tbl_low[r];
                tbl_high[w] = tbl_high[r];
                tbl_val[w] = tbl_val[r];
            end
        end
        tbl_count = w + 1;
    endfunction

    function automatic logic [1:0] bind_range(logic [63:0] lo, logic [63:0] hi,
                                              logic [63:0] v);
        int  extra;
        int  a;
        int  b;
        bit  top;
        extra = 0;
        top = (hi == KEY_TOP);
        if (lo > hi) return ST_BAD_RANGE;
        if (tbl_low[find_range(lo)] != lo) extra++;
        if (!top && tbl_low[find_range(hi + 64'd1)] != hi + 64'd1) extra++;
        if (tbl_count + extra > DEPTH) return ST_FULL;
        cut_at(lo);
        if (!top) cut_at(hi + 64'd1);
        a = find_range(lo);
        b = find_range(hi);
        for (int i = a; i <= b; i++) tbl_val[i] = v;
        join_equal();
        return ST_OK;
    endfunction

    function automatic t_answer predict_answer(t_request rq);
        t_answer an;
        int      i;
        an = '{ST_OK, '0, '0, '0, '0};
        case (rq.action)
            ACT_BIND: begin
                an.status = bind_range(rq.bind_low, rq.bind_high, rq.bind_value);
            end
            ACT_LOOKUP: begin
                i = find_range(rq.search_key);
                an.found_low = tbl_low[i];
                an.found_high = tbl_high[i];
                an.found_value = tbl_val[i];
            end
            ACT_READ: begin
                if (rq.entry_index < tbl_count) begin
                    an.found_low = tbl_low[rq.entry_index];
                    an.found_high = tbl_high[rq.entry_index];
                    an.found_value = tbl_val[rq.entry_index];
                end else begin
                    an.status = ST_BAD_INDEX;
                end
            end
            default: ;
        endcase
        an.range_count = tbl_count[6:0];
        return an;
    endfunction

    // driver: predict on accept, then present the next request
    always @(posedge i_clk) begin
        t_request rq;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                rq = '{i_action, i_bind_low, i_bind_high, i_bind_value,
                       i_search_key, i_entry_index};
                answer_q.push_back(predict_answer(rq));
            end
            if (!i_start || !o_busy) begin
                if (pending_q.size() != 0 && (quiet_sender || $urandom_range(99) >= 20)) begin
                    rq = pending_q.pop_front();
                    i_action <= rq.action;
                    i_bind_low <= rq.bind_low;
                    i_bind_high <= rq.bind_high;
                    i_bind_value <= rq.bind_value;
                    i_search_key <= rq.search_key;
                    i_entry_index <= rq.entry_index;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result against the oldest prediction
    always @(posedge i_clk) begin
        t_answer an;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (answer_q.size() == 0) begin
                $display("%0t unexpected result status=%0d", $time, o_status);
                errors++;
            end else begin
                an = answer_q.pop_front();
                if (an.status == ST_FULL) n_full++;
                if (o_status !== an.status) begin
                    $display("%0t status exp %0d got %0d", $time, an.status, o_status);
                    errors++;
                end
                if (o_found_low !== an.found_low) begin
                    $display("%0t found_low exp %h got %h", $time, an.found_low, o_found_low);
                    errors++;
                end
                if (o_found_high !== an.found_high) begin
                    $display("%0t found_high exp %h got %h", $time, an.found_high,
                             o_found_high);
                    errors++;
                end
                if (o_found_value !== an.found_value) begin
                    $display("%0t found_value exp %h got %h", $time, an.found_value,
                             o_found_value);
                    errors++;
                end
                if (o_range_count !== an.range_count) begin
                    $display("%0t range_count exp %0d got %0d", $time, an.range_count,
                             o_range_count);
                    errors++;
                end
            end
        end
    end

    // keys mostly from a small neighborhood so ranges overlap
    function automatic logic [63:0] pick_key();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return KEY_TOP;
            2: return KEY_TOP - 64'($urandom_range(40));
            3: return {$urandom, $urandom};
            default: return 64'($urandom_range(120));
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return 64'($urandom_range(5));
    endfunction

    function automatic t_request mk(logic [1:0] act, logic [63:0] lo, logic [63:0] hi,
                                    logic [63:0] v, logic [63:0] key, logic [5:0] ix);
        t_request rq;
        rq = '{act, lo, hi, v, key, ix};
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request    rq;
        logic [63:0] a;
        logic [63:0] b;
        rq = mk(2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, 6'($urandom));
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                a = pick_key();
                b = pick_key();
                rq.action = ACT_BIND;
                if ($urandom_range(7) != 0 && a > b) {a, b} = {b, a};
                rq.bind_low = a;
                rq.bind_high = b;
                rq.bind_value = pick_value();
            end
            4, 5: begin
                rq.action = ACT_LOOKUP;
                rq.search_key = pick_key();
            end
            6, 7: rq.action = ACT_READ;
            default: ;
        endcase
        return rq;
    endfunction

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_q.size() != 0 || i_start || answer_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_init(logic [63:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        table_reinit(v);
    endtask

    // stimulus phases
    initial begin
        table_reinit('0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        pending_q.push_back(mk(ACT_LOOKUP, 0, 0, 0, 64'd0, 0));
        pending_q.push_back(mk(ACT_LOOKUP, 0, 0, 0, KEY_TOP, 0));
        pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 6'd0));
        pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 6'd63));
        pending_q.push_back(mk(ACT_BIND, 64'd9, 64'd8, 64'd5, 0, 0));
        pending_q.push_back(mk(ACT_BIND, 64'd10, 64'd20, 64'd7, 0, 0));
        pending_q.push_back(mk(ACT_BIND, 64'd0, 64'd0, KEY_TOP, 0, 0));
        pending_q.push_back(mk(ACT_BIND, KEY_TOP, KEY_TOP, 64'd3, 0, 0));
        pending_q.push_back(mk(ACT_BIND, 64'd100, KEY_TOP, 64'd3, 0, 0));
        pending_q.push_back(mk(ACT_LOOKUP, 0, 0, 0, 64'd15, 0));
        pending_q.push_back(mk(ACT_LOOKUP, 0, 0, 0, KEY_TOP - 1, 0));
        pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 6'd1));
        pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 6'd4));
        pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 6'd5));
        pending_q.push_back(mk(2'd3, KEY_TOP, KEY_TOP, KEY_TOP, KEY_TOP, 6'd63));
        pending_q.push_back(mk(ACT_BIND, 64'd15, 64'd15, 64'd7, 0, 0));
        pending_q.push_back(mk(ACT_BIND, 64'd5, 64'd30, 64'd0, 0, 0));
        pending_q.push_back(mk(ACT_BIND, KEY_TOP, 64'd0, 64'd1, 0, 0));
        pending_q.push_back(mk(ACT_BIND, 64'd0, KEY_TOP, 64'd9, 0, 0));
        pending_q.push_back(mk(ACT_READ, 0, 0, 0, 0, 6'd0));
        wait_drained();

        // random mix with idling
        write_init(KEY_TOP);
        for (int n = 0; n < 150; n++) pending_q.push_back(random_request());
        wait_drained();

        // fill to capacity, no idling
        write_init({$urandom, $urandom});
        quiet_sender = 1'b1;
        for (int n = 0; n < 40; n++)
            pending_q.push_back(mk(ACT_BIND, 64'(4 * n + 1), 64'(4 * n + 2),
                                   64'(n + 100), 0, 0));
        for (int n = 0; n < 60; n++) pending_q.push_back(random_request());
        wait_drained();
        quiet_sender = 1'b0;

        // random mix again from an all-zero table
        write_init('0);
        for (int n = 0; n < 200; n++) pending_q.push_back(random_request());
        wait_drained();

        $display("covered %0d results across four table settings, %0d capacity refusals",
                 n_results, n_full);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/imbl_pkg.sv
rtl/core/imbl_ram.sv
rtl/core/interval_map_bind_lookup.sv
tb/sv/tb_top.sv
